// ===== hdl/fgr_pkg.sv =====
// Shared types, register indexes and mode codes of the frame geometric remap block.
package fgr_pkg;

    localparam int MAX_SIDE_DEF = 512;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SIDE_W     = 10;
    localparam int COORD_W    = 9;
    localparam int PIX_W      = 8;
    localparam int Q_FRAC     = 14;
    localparam int SRC_W      = 14;
    localparam int DIFF_W     = 11;
    localparam int PROD_W     = 27;
    localparam int SUM_W      = 28;
    localparam int ZOOM_W     = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 3'd5;

    localparam logic [2:0] MODE_IDENTITY  = 3'd0;
    localparam logic [2:0] MODE_MIRROR_LR = 3'd1;
    localparam logic [2:0] MODE_MIRROR_UD = 3'd2;
    localparam logic [2:0] MODE_SHIFT     = 3'd3;
    localparam logic [2:0] MODE_ZOOM_OUT  = 3'd4;
    localparam logic [2:0] MODE_ROTATE    = 3'd5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic [2:0]        mode;
        logic [SIDE_W-1:0] image_side;
        logic signed [10:0] shift_offset;
        logic [4:0]        zoom_scale;
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic in_frame;
    } map_status_t;

endpackage

// ===== hdl/fgr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module fgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fgr_map.sv =====
// Four-stage coordinate mapper from output pixel to source address and inside flag.
module fgr_map #(
    parameter int MAX_SIDE = fgr_pkg::MAX_SIDE_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [fgr_pkg::COORD_W-1:0]                row,
    input  logic [fgr_pkg::COORD_W-1:0]                col,
    input  fgr_pkg::cfg_t                              cfg,
    input  logic [fgr_pkg::SIDE_W-1:0]                 side_n,
    output fgr_pkg::map_status_t                       status,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]       addr
);
    import fgr_pkg::*;

    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam logic [31:0] MAX_U = 32'(MAX_SIDE);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    logic [COORD_W-1:0] r1_reg, c1_reg, r2_reg, c2_reg;
    logic               ok1_reg, ok2_reg, ok3_reg;
    logic               ok1_next, ok2_next, ok3_next;
    logic signed [PROD_W-1:0] pcr_reg, psc_reg, pcc_reg, psr_reg;
    logic signed [PROD_W-1:0] pcr_next, psc_next, pcc_next, psr_next;
    logic [ZOOM_W-1:0]  zr_reg, zc_reg;
    logic [ZOOM_W-1:0]  zr_next, zc_next;
    logic signed [SUM_W-1:0] sum_r_reg, sum_c_reg;
    logic signed [SUM_W-1:0] sum_r_next, sum_c_next;
    logic               zok_reg, zok_next;
    logic [ZOOM_W-1:0]  zsr_reg, zsc_reg;
    logic signed [SRC_W-1:0] sr_reg, sc_reg, sr_next, sc_next;
    logic               inside_reg, inside_next;
    logic [AW-1:0]      addr_reg, addr_next;

    logic signed [DIFF_W-1:0] dr, dc;
    logic [4:0]               scale;
    logic signed [SRC_W-1:0]  cx, n_s, q_r, q_c;
    logic                     corr_r, corr_c;

    assign n_s = signed'({4'b0, side_n});
    assign cx  = signed'({5'b0, side_n[SIDE_W-1:1]});

    // First stage: products for rotation and zoom, and the output-frame check.
    always_comb
    begin
        dr = signed'({2'b0, row}) - signed'({2'b0, side_n[SIDE_W-1:1]});
        dc = signed'({2'b0, col}) - signed'({2'b0, side_n[SIDE_W-1:1]});
        scale = (cfg.zoom_scale == 5'd0) ? 5'd1 : cfg.zoom_scale;
        v1_next  = start;
        ok1_next = ({1'b0, row} < side_n) && ({1'b0, col} < side_n);
        pcr_next = PROD_W'(cfg.cos_q14) * PROD_W'(dr);
        psc_next = PROD_W'(cfg.sin_q14) * PROD_W'(dc);
        pcc_next = PROD_W'(cfg.cos_q14) * PROD_W'(dc);
        psr_next = PROD_W'(cfg.sin_q14) * PROD_W'(dr);
        zr_next  = ZOOM_W'({1'b0, row} + 10'd1) * ZOOM_W'(scale);
        zc_next  = ZOOM_W'({1'b0, col} + 10'd1) * ZOOM_W'(scale);
    end

    // Second stage: rotation sums and the zoomed output-frame check.
    always_comb
    begin
        v2_next    = v1_reg;
        ok2_next   = ok1_reg;
        sum_r_next = SUM_W'(pcr_reg) + SUM_W'(psc_reg);
        sum_c_next = SUM_W'(pcc_reg) - SUM_W'(psr_reg);
        zok_next   = (zr_reg <= ZOOM_W'(side_n)) && (zc_reg <= ZOOM_W'(side_n));
    end

    // Third stage: source coordinate by mode; quotients truncate toward zero.
    always_comb
    begin
        corr_r = sum_r_reg[SUM_W-1] && (sum_r_reg[Q_FRAC-1:0] != '0);
        corr_c = sum_c_reg[SUM_W-1] && (sum_c_reg[Q_FRAC-1:0] != '0);
        q_r = signed'(sum_r_reg[SUM_W-1:Q_FRAC]) + signed'({13'b0, corr_r});
        q_c = signed'(sum_c_reg[SUM_W-1:Q_FRAC]) + signed'({13'b0, corr_c});
        v3_next  = v2_reg;
        ok3_next = ok2_reg;
        sr_next  = signed'({5'b0, r2_reg});
        sc_next  = signed'({5'b0, c2_reg});
        case (cfg.mode)
            MODE_MIRROR_LR:
            begin
                sc_next = n_s - 14'sd1 - signed'({5'b0, c2_reg});
            end
            MODE_MIRROR_UD:
            begin
                sr_next = n_s - 14'sd1 - signed'({5'b0, r2_reg});
            end
            MODE_SHIFT:
            begin
                sr_next = signed'({5'b0, r2_reg}) - SRC_W'(cfg.shift_offset);
                sc_next = signed'({5'b0, c2_reg}) - SRC_W'(cfg.shift_offset);
            end
            MODE_ZOOM_OUT:
            begin
                ok3_next = ok2_reg && zok_reg;
                sr_next  = signed'(SRC_W'(zsr_reg - ZOOM_W'(1)));
                sc_next  = signed'(SRC_W'(zsc_reg - ZOOM_W'(1)));
            end
            MODE_ROTATE:
            begin
                sr_next = cx + q_r;
                sc_next = cx + q_c;
            end
            default:
            begin
                sr_next = signed'({5'b0, r2_reg});
                sc_next = signed'({5'b0, c2_reg});
            end
        endcase
    end

    // Fourth stage: bounds check and store address.
    always_comb
    begin
        v4_next     = v3_reg;
        inside_next = ok3_reg && (sr_reg >= 14'sd0) && (sr_reg < n_s)
                      && (sc_reg >= 14'sd0) && (sc_reg < n_s);
        addr_next   = AW'(32'(sr_reg[SIDE_W-1:0]) * MAX_U + 32'(sc_reg[SIDE_W-1:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg     <= row;
        c1_reg     <= col;
        ok1_reg    <= ok1_next;
        pcr_reg    <= pcr_next;
        psc_reg    <= psc_next;
        pcc_reg    <= pcc_next;
        psr_reg    <= psr_next;
        zr_reg     <= zr_next;
        zc_reg     <= zc_next;
        r2_reg     <= r1_reg;
        c2_reg     <= c1_reg;
        ok2_reg    <= ok2_next;
        sum_r_reg  <= sum_r_next;
        sum_c_reg  <= sum_c_next;
        zok_reg    <= zok_next;
        zsr_reg    <= zr_reg;
        zsc_reg    <= zc_reg;
        ok3_reg    <= ok3_next;
        sr_reg     <= sr_next;
        sc_reg     <= sc_next;
        inside_reg <= inside_next;
        addr_reg   <= addr_next;
    end

    assign status.done     = v4_reg;
    assign status.in_frame = inside_reg;
    assign addr            = addr_reg;

endmodule

// ===== hdl/frame_geometric_remap.sv =====
// Top level of the frame geometric remap block: configuration, sequencer, store and output.
//
// The block holds one square grayscale frame in a synchronous RAM of MAX_SIDE by MAX_SIDE
// bytes, addressed row * MAX_SIDE + col. Items arrive on the in_valid/in_ready channel.
// A load item (action 0) writes pixel_in into the frame in the cycle of its transfer and
// gives no result; loads can follow each other every cycle. A read item (action 1) names
// an output coordinate; the four-stage mapper turns it into a source address, the RAM is
// read into its read register and the pixel then moves into the output register. The next
// item is taken once the result has moved into the output register, so no new item enters
// while a read is in flight. A new item may be taken while a finished result still waits
// on out_valid/out_ready; if the receiver stalls, a second read waits with its pixel held
// in the RAM read register until the output register frees. Registers are written through
// cfg_wr_en, cfg_index and cfg_data, and the user must write them only while the block
// is idle; the block itself does not enforce this. Reset restores the register defaults
// and empties the pipeline and output register; the frame contents are undefined until
// loaded.
module frame_geometric_remap #(
    parameter int MAX_SIDE = fgr_pkg::MAX_SIDE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fgr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [fgr_pkg::COORD_W-1:0]        row,
    input  logic [fgr_pkg::COORD_W-1:0]        col,
    input  logic [fgr_pkg::PIX_W-1:0]          pixel_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fgr_pkg::PIX_W-1:0]          pixel_out,
    output logic                               inside_res
);
    import fgr_pkg::*;

    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam logic [31:0] MAX_U = 32'(MAX_SIDE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAP  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    cfg_t cfg_reg, cfg_next;
    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pixel_out_reg, pixel_out_next;
    logic       inside_out_reg, inside_out_next;
    logic       hit_reg, hit_next;

    logic [SIDE_W-1:0] side_n;
    logic              in_xfer, load_ok, ram_we, ram_re, map_start;
    logic [AW-1:0]     waddr, raddr;
    logic [PIX_W-1:0]  rdata;
    map_status_t       map_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE:   cfg_next.mode         = cfg_data[2:0];
                CFG_SIDE:   cfg_next.image_side   = cfg_data[SIDE_W-1:0];
                CFG_OFFSET: cfg_next.shift_offset = signed'(cfg_data[10:0]);
                CFG_SCALE:  cfg_next.zoom_scale   = cfg_data[4:0];
                CFG_COS:    cfg_next.cos_q14      = signed'(cfg_data);
                CFG_SIN:    cfg_next.sin_q14      = signed'(cfg_data);
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_reg.image_side == '0)
        begin
            side_n = SIDE_W'(1);
        end
        else if (32'(cfg_reg.image_side) > MAX_U)
        begin
            side_n = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_n = cfg_reg.image_side;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign load_ok   = (32'(row) < MAX_U) && (32'(col) < MAX_U);
    assign ram_we    = in_xfer && (action == ACT_LOAD) && load_ok;
    assign waddr     = AW'(32'(row) * MAX_U + 32'(col));
    assign map_start = in_xfer && (action == ACT_READ);
    assign ram_re    = (state_reg == ST_MAP) && map_status.done && map_status.in_frame;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_out_next  = pixel_out_reg;
        inside_out_next = inside_out_reg;
        hit_next        = hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (map_start)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (map_status.done)
                begin
                    hit_next   = map_status.in_frame;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    pixel_out_next  = hit_reg ? rdata : '0;
                    inside_out_next = hit_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_IDENTITY;
            cfg_reg.image_side   <= SIDE_W'(512);
            cfg_reg.shift_offset <= '0;
            cfg_reg.zoom_scale   <= 5'd1;
            cfg_reg.cos_q14      <= 16'sd16384;
            cfg_reg.sin_q14      <= '0;
            state_reg            <= ST_IDLE;
            out_valid_reg        <= 1'b0;
            hit_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg  <= pixel_out_next;
        inside_out_reg <= inside_out_next;
    end

    fgr_map #(
        .MAX_SIDE (MAX_SIDE)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (map_start),
        .row    (row),
        .col    (col),
        .cfg    (cfg_reg),
        .side_n (side_n),
        .status (map_status),
        .addr   (raddr)
    );

    fgr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (pixel_in),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign inside_res = inside_out_reg;

    // A read transfer closes the input until its result has been handed on.
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == ACT_READ) |=> !in_ready)
        else $error("input still open after a read transfer");

    // A source outside the frame always reports a zero pixel.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !inside_res) |-> (pixel_out == '0))
        else $error("non-zero pixel reported for an outside source");

    // The mapper finishes only while the sequencer waits for it.
    a_map_done: assert property (@(posedge clk) disable iff (!rst_n)
        map_status.done |-> (state_reg == ST_MAP))
        else $error("mapper finished outside the wait state");

    // A new result appears only when the sequencer leaves the data state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DATA))
        else $error("result raised without a completed read");

endmodule

// ===== tb/remap_checker.sv =====
// Checker for the frame geometric remap block: watches both channels, predicts and compares.
module remap_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fgr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           action,
    input  logic [fgr_pkg::COORD_W-1:0]    row,
    input  logic [fgr_pkg::COORD_W-1:0]    col,
    input  logic [fgr_pkg::PIX_W-1:0]      pixel_in,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [fgr_pkg::PIX_W-1:0]      pixel_out,
    input  logic                           inside_res,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fgr_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             in_frame;
    } remap_result_t;

    cfg_t             geometry;
    logic [PIX_W-1:0] frame_copy [0:MAX_SIDE_DEF*MAX_SIDE_DEF-1];
    remap_result_t    expected_pixels [$];
    remap_result_t    oldest;
    int               errors = 0;

    function automatic remap_result_t remap_pixel(input int r, input int c);
        remap_result_t res;
        int     n;
        int     sr;
        int     sc;
        int     s;
        int     zoom_side;
        int     cx;
        int     off;
        longint dr;
        longint dc;
        longint cs;
        longint sn;
        logic   ok;
        n = int'(geometry.image_side);
        if (n < 1) n = 1;
        if (n > MAX_SIDE_DEF) n = MAX_SIDE_DEF;
        ok = (r < n) && (c < n);
        sr = r;
        sc = c;
        if (ok)
        begin
            case (geometry.mode)
                MODE_MIRROR_LR: sc = n - 1 - c;
                MODE_MIRROR_UD: sr = n - 1 - r;
                MODE_SHIFT:
                begin
                    off = $signed(geometry.shift_offset);
                    sr = r - off;
                    sc = c - off;
                end
                MODE_ZOOM_OUT:
                begin
                    s = (geometry.zoom_scale == 0) ? 1 : int'(geometry.zoom_scale);
                    zoom_side = n / s;
                    if (r >= zoom_side || c >= zoom_side)
                        ok = 1'b0;
                    else
                    begin
                        sr = r * s + s - 1;
                        sc = c * s + s - 1;
                    end
                end
                MODE_ROTATE:
                begin
                    // The scaled sums are truncated toward zero, as signed division does.
                    cx = n / 2;
                    dr = r - cx;
                    dc = c - cx;
                    cs = $signed(geometry.cos_q14);
                    sn = $signed(geometry.sin_q14);
                    sr = cx + int'((cs * dr + sn * dc) / 16384);
                    sc = cx + int'((cs * dc - sn * dr) / 16384);
                end
                default: ;
            endcase
        end
        if (ok)
            ok = (sr >= 0) && (sr < n) && (sc >= 0) && (sc < n);
        if (ok)
        begin
            res.pixel    = frame_copy[sr * MAX_SIDE_DEF + sc];
            res.in_frame = 1'b1;
        end
        else
        begin
            res.pixel    = '0;
            res.in_frame = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geometry.mode         = MODE_IDENTITY;
            geometry.image_side   = SIDE_W'(MAX_SIDE_DEF);
            geometry.shift_offset = '0;
            geometry.zoom_scale   = 5'd1;
            geometry.cos_q14      = 16'sd16384;
            geometry.sin_q14      = '0;
            expected_pixels.delete();
            errors = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE:   geometry.mode         = cfg_data[2:0];
                    CFG_SIDE:   geometry.image_side   = cfg_data[SIDE_W-1:0];
                    CFG_OFFSET: geometry.shift_offset = cfg_data[10:0];
                    CFG_SCALE:  geometry.zoom_scale   = cfg_data[4:0];
                    CFG_COS:    geometry.cos_q14      = cfg_data;
                    CFG_SIN:    geometry.sin_q14      = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: pixel_out %0d inside_res %0b",
                                 pixel_out, inside_res);
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (pixel_out !== oldest.pixel || inside_res !== oldest.in_frame)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: pixel_out exp %0d got %0d, inside_res exp %0b got %0b",
                                     oldest.pixel, pixel_out, oldest.in_frame, inside_res);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (action == ACT_LOAD)
                    frame_copy[int'(row) * MAX_SIDE_DEF + int'(col)] = pixel_in;
                else
                    expected_pixels.push_back(remap_pixel(int'(row), int'(col)));
            end
            pending    <= expected_pixels.size();
            fail_count <= errors;
        end
    end

endmodule

// ===== tb/frame_geometric_remap_test.sv =====
// Top of the frame geometric remap testbench: clock, reset, stimulus and verdict.
module frame_geometric_remap_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fgr_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int RUN_LIMIT       = 4000000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int FILL_SIDE       = 16;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  action = ACT_LOAD;
    logic [COORD_W-1:0]    row = '0;
    logic [COORD_W-1:0]    col = '0;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  inside_res;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        burst_max = 64;
    int        gap_max = 2;
    int        rx_left = 0;
    rx_style_t rx_style = RX_ALWAYS;
    logic      rx_take = 1'b0;
    logic      hold_off = 1'b0;
    logic      random_phase_on = 1'b0;

    frame_geometric_remap u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .row        (row),
        .col        (col),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .inside_res (inside_res)
    );

    remap_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .row        (row),
        .col        (col),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .inside_res (inside_res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Bits above the register width carry random junk, which the block must ignore.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int bits);
        int keep;
        keep = (bits >= CFG_DATA_W) ? 32'hFFFF : ((1 << bits) - 1);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'((value & keep) | ($urandom() & ~keep));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_geometry(input logic [2:0] m, input int side, input int off,
                                    input int scale, input int cs, input int sn);
        write_reg(CFG_MODE, m, 3);
        write_reg(CFG_SIDE, side, SIDE_W);
        write_reg(CFG_OFFSET, off, 11);
        write_reg(CFG_SCALE, scale, 5);
        write_reg(CFG_COS, cs, 16);
        write_reg(CFG_SIN, sn, 16);
    endtask

    task automatic send_item(input logic act, input int r, input int c, input int p);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(gap_max);
            burst_left = $urandom_range(burst_max, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action   <= act;
        row      <= r[COORD_W-1:0];
        col      <= c[COORD_W-1:0];
        pixel_in <= p[PIX_W-1:0];
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style = rx_style_t'($urandom_range(3));
            rx_left  = $urandom_range(120, 10);
        end
        rx_left--;
        case (rx_style)
            RX_ALWAYS: rx_take = 1'b1;
            RX_COIN:   rx_take = ($urandom_range(1) == 1);
            RX_SPARSE: rx_take = ($urandom_range(4) == 0);
            default:   rx_take = (rx_left % 8) < 5;
        endcase
        out_ready <= rx_take && !hold_off;
    end

    // The long receiver stall lets the block fill up while the sender keeps offering reads.
    initial
    begin
        wait (random_phase_on);
        repeat (60) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int         r;
        int         c;
        int         phase;
        int         side;
        int         off;
        int         scale;
        int         cs;
        int         sn;
        int         n_eff;
        int         s_eff;
        int         span;
        int         pick;
        int         n_items;
        logic [2:0] m;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry that a read can reach is written before anything reads it.
        for (r = 0; r < FILL_SIDE; r++)
            for (c = 0; c < FILL_SIDE; c++)
                send_item(ACT_LOAD, r, c, $urandom_range(255));
        send_item(ACT_LOAD, 0, 511, $urandom_range(255));
        send_item(ACT_LOAD, 511, 511, $urandom_range(255));
        send_item(ACT_LOAD, 495, 495, $urandom_range(255));
        send_item(ACT_LOAD, 511, 1, $urandom_range(255));
        send_item(ACT_LOAD, 342, 164, $urandom_range(255));
        settle();

        send_item(ACT_READ, 0, 0, $urandom_range(255));
        send_item(ACT_READ, 511, 511, $urandom_range(255));
        send_item(ACT_LOAD, 511, 511, 8'hFF);
        send_item(ACT_READ, 511, 511, 8'h00);
        send_item(ACT_LOAD, 0, 0, 8'h00);
        send_item(ACT_READ, 0, 0, 8'hFF);
        settle();
        program_geometry(MODE_MIRROR_LR, MAX_SIDE_DEF, 0, 1, 16384, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_READ, 7, 511, 0);
        settle();
        program_geometry(MODE_MIRROR_UD, 2, 0, 1, 16384, 0);
        send_item(ACT_READ, 0, 1, 0);
        send_item(ACT_READ, 1, 2, 0);
        settle();
        program_geometry(MODE_SHIFT, MAX_SIDE_DEF, 5, 1, 16384, 0);
        send_item(ACT_READ, 5, 5, 0);
        send_item(ACT_READ, 4, 9, 0);
        settle();
        program_geometry(MODE_SHIFT, MAX_SIDE_DEF, -1024, 1, 16384, 0);
        send_item(ACT_READ, 0, 0, 0);
        settle();
        program_geometry(MODE_ZOOM_OUT, MAX_SIDE_DEF, 0, 0, 16384, 0);
        send_item(ACT_READ, 3, 3, 0);
        settle();
        program_geometry(MODE_ZOOM_OUT, MAX_SIDE_DEF, 0, 16, 16384, 0);
        send_item(ACT_READ, 31, 31, 0);
        send_item(ACT_READ, 32, 0, 0);
        settle();
        program_geometry(MODE_ZOOM_OUT, MAX_SIDE_DEF, 0, 31, 16384, 0);
        send_item(ACT_READ, 15, 15, 0);
        send_item(ACT_READ, 16, 16, 0);
        settle();
        program_geometry(MODE_ROTATE, MAX_SIDE_DEF, 0, 1, 0, 16384);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_READ, 511, 511, 0);
        settle();
        program_geometry(MODE_ROTATE, 511, 0, 1, -32768, 32767);
        send_item(ACT_READ, 256, 300, 0);
        settle();
        program_geometry(MODE_SPARE_A, MAX_SIDE_DEF, 0, 1, 16384, 0);
        send_item(ACT_READ, 1, 2, 0);
        settle();
        program_geometry(MODE_SPARE_B, MAX_SIDE_DEF, 0, 1, 16384, 0);
        send_item(ACT_READ, 3, 4, 0);
        settle();
        program_geometry(MODE_IDENTITY, 0, 0, 1, 16384, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_READ, 0, 1, 0);
        settle();
        program_geometry(MODE_IDENTITY, 1023, 0, 1, 16384, 0);
        send_item(ACT_READ, 511, 511, 0);

        random_phase_on = 1'b1;
        for (phase = 0; phase < 10; phase++)
        begin
            settle();
            if (phase < 8)
                m = 3'(phase);
            else if (phase == 8)
                m = MODE_ROTATE;
            else
                m = MODE_SHIFT;
            pick = $urandom_range(9);
            if (pick < 8)
                side = $urandom_range(FILL_SIDE, 1);
            else if (pick == 8)
                side = FILL_SIDE;
            else
                side = 0;
            n_eff = (side < 1) ? 1 : (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side;
            scale = ($urandom_range(1) == 1) ? $urandom_range(31) : $urandom_range(4, 1);
            s_eff = (scale == 0) ? 1 : scale;
            span  = (m == MODE_ZOOM_OUT) ? n_eff / s_eff : n_eff;
            if (span < 1) span = 1;
            if ($urandom_range(1) == 1)
                off = int'($urandom_range(2047)) - 1024;
            else
                off = int'($urandom_range(2 * span)) - span;
            case ($urandom_range(5))
                0:
                begin
                    cs = 14189;
                    sn = 8192;
                end
                1:
                begin
                    cs = 11585;
                    sn = -11585;
                end
                2:
                begin
                    cs = -8192;
                    sn = 14189;
                end
                3:
                begin
                    cs = 0;
                    sn = -16384;
                end
                4:
                begin
                    cs = -16384;
                    sn = 0;
                end
                default:
                begin
                    cs = int'($urandom_range(65535)) - 32768;
                    sn = int'($urandom_range(65535)) - 32768;
                end
            endcase
            program_geometry(m, side, off, scale, cs, sn);
            burst_max = $urandom_range(40, 4);
            gap_max   = (phase % 3 == 2) ? 0 : $urandom_range(8, 1);
            n_items   = (phase == 0) ? 60 : 30;
            repeat (n_items)
            begin
                pick = $urandom_range(7);
                if (pick < 2)
                    send_item(ACT_LOAD, $urandom_range(511), $urandom_range(511),
                              $urandom_range(255));
                else if (pick == 2)
                    send_item(ACT_READ, $urandom_range(511), $urandom_range(511),
                              $urandom_range(255));
                else
                    send_item(ACT_READ, $urandom_range(span - 1), $urandom_range(span - 1),
                              $urandom_range(255));
            end
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/fgr_pkg.sv
hdl/fgr_ram.sv
hdl/fgr_map.sv
hdl/frame_geometric_remap.sv
tb/remap_checker.sv
tb/frame_geometric_remap_test.sv
